// File: sv/hierarchical_bitmap_ordered_set_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap ordered set
// Clocked property checks; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_BITMAP_ORDERED_SET_ASSERT_SVH
`define HIERARCHICAL_BITMAP_ORDERED_SET_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HBOS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hbos: assertion failed");
`define HBOS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hbos: assertion failed");
`else
`define HBOS_ASSERT(lbl, clk, rst_n, prop)
`define HBOS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/hbos_pkg.sv
// ----------------------------------------------------------------------------
// hbos_pkg
// Shared constants, codes, control structs and bit-scan functions.
// ----------------------------------------------------------------------------
package hbos_pkg;

  localparam int unsigned CAPACITY   = 4096;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned LEAF_COUNT = CAPACITY / WORD_W;
  localparam int unsigned BIT_AW     = $clog2(WORD_W);
  localparam int unsigned LEAF_AW    = $clog2(LEAF_COUNT);
  localparam int unsigned ELEM_W     = LEAF_AW + BIT_AW;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned KEY_W      = 14;
  localparam int unsigned UNIV_W     = 13;
  localparam int unsigned STAT_W     = 2;

  localparam logic [UNIV_W-1:0] UNIV_RESET = UNIV_W'(CAPACITY);
  localparam logic [UNIV_W-1:0] UNIV_MAX   = UNIV_W'(CAPACITY);
  localparam logic [KEY_W-1:0]  FOUND_NONE = '1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_ERASE    = 3'd1,
    CMD_CONTAINS = 3'd2,
    CMD_LOWER    = 3'd3,
    CMD_UPPER    = 3'd4,
    CMD_PRED     = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FALSE = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_EV1,
    S_RD2,
    S_EV2,
    S_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd1;
    logic ev1;
    logic rd2;
    logic ev2;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic early;
    logic chain;
  } dp_stat_t;

  function automatic logic [BIT_AW-1:0] lsb_index(word_t v);
    word_t t;
    logic [BIT_AW-1:0] r;
    t = v;
    r = '0;
    for (int i = BIT_AW - 1; i >= 0; i--) begin
      if ((t & ((word_t'(1) << (1 << i)) - word_t'(1))) == '0) begin
        r[i] = 1'b1;
        t    = t >> (1 << i);
      end
    end
    return r;
  endfunction

  function automatic logic [BIT_AW-1:0] msb_index(word_t v);
    word_t t;
    logic [BIT_AW-1:0] r;
    t = v;
    r = '0;
    for (int i = BIT_AW - 1; i >= 0; i--) begin
      if ((t >> (1 << i)) != '0) begin
        r[i] = 1'b1;
        t    = t >> (1 << i);
      end
    end
    return r;
  endfunction

endpackage

// File: sv/hbos_if.sv
// ----------------------------------------------------------------------------
// hbos channel interfaces
// Command, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbos_cmd_if;
  import hbos_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [KEY_W-1:0] key;
  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface hbos_res_if;
  import hbos_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [KEY_W-1:0] found_value;
  logic [UNIV_W-1:0]       element_count;
  modport source (output valid, output status, output found_value, output element_count,
                  input ready);
  modport sink   (input valid, input status, input found_value, input element_count,
                  output ready);
endinterface

interface hbos_cfg_if;
  import hbos_pkg::*;
  logic              valid;
  logic              ready;
  logic [UNIV_W-1:0] universe_size;
  modport source (output valid, output universe_size, input ready);
  modport sink   (input valid, input universe_size, output ready);
endinterface

// File: sv/hierarchical_bitmap_ordered_set.sv
// ----------------------------------------------------------------------------
// hierarchical_bitmap_ordered_set
// Ordered integer set on a two-level 64-ary bitmap with successor and predecessor searches.
// ----------------------------------------------------------------------------
// Channels: cmd_i carries one command transaction (command, key); res_o
// returns exactly one result transaction (status, found_value,
// element_count) per command, in order; cfg_i writes universe_size and is
// always ready. Write cfg_i only while no command is in flight.
// Sequence after accept: commands settled from the key alone (out-of-range
// key, empty search range, unused code) go straight to the output stage;
// insert, erase, contains and searches settled in the key's own leaf word
// take one leaf read and evaluation, and searches that move to another leaf
// word take a second read and evaluation. One command is in flight at a
// time; the leaf RAM has a single read port with registered read data.
// Reset: the set is empty and universe_size is 4096, usable at once; summary
// bits mark valid leaf words, so the leaf RAM needs no clearing pass.
// Stall: the result register holds until taken; a new command is accepted
// meanwhile and waits with its result until the register frees up.
// ----------------------------------------------------------------------------
module hierarchical_bitmap_ordered_set (
  input logic        clk_i,
  input logic        rst_ni,
  hbos_cmd_if.sink   cmd_i,
  hbos_res_if.source res_o,
  hbos_cfg_if.sink   cfg_i
);
  import hbos_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t stat;
  logic     cmd_ready;
  logic     res_valid;

  hbos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  hbos_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cfg_we_i        (cfg_i.valid),
    .cfg_data_i      (cfg_i.universe_size),
    .command_i       (cmd_i.command),
    .key_i           (cmd_i.key),
    .status_o        (res_o.status),
    .found_value_o   (res_o.found_value),
    .element_count_o (res_o.element_count)
  );

  assign cmd_i.ready = cmd_ready;
  assign res_o.valid = res_valid;
  assign cfg_i.ready = 1'b1;

endmodule

// File: sv/hbos_ram.sv
// ----------------------------------------------------------------------------
// hbos_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbos_ram #(
  parameter int unsigned WIDTH = hbos_pkg::WORD_W,
  parameter int unsigned DEPTH = hbos_pkg::LEAF_COUNT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/hbos_ctrl.sv
// ----------------------------------------------------------------------------
// hbos_ctrl
// Command sequencer: early exit or leaf read, evaluate, optional second leaf pass, output.
// ----------------------------------------------------------------------------
`include "hierarchical_bitmap_ordered_set_assert.svh"

module hbos_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  input  hbos_pkg::dp_stat_t stat_i,
  output hbos_pkg::ctrl_t    ctrl_o
);
  import hbos_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = stat_i.early ? S_OUT : S_RD1;
        end
      end
      S_RD1: state_d = S_EV1;
      S_EV1: state_d = stat_i.chain ? S_RD2 : S_OUT;
      S_RD2: state_d = S_EV2;
      S_EV2: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    cmd_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_ready_o   = 1'b1;
        ctrl_o.accept = cmd_valid_i;
      end
      S_RD1: ctrl_o.rd1 = 1'b1;
      S_EV1: ctrl_o.ev1 = 1'b1;
      S_RD2: ctrl_o.rd2 = 1'b1;
      S_EV2: ctrl_o.ev2 = 1'b1;
      S_OUT: ctrl_o.load_out = !out_valid_q || res_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;

  `HBOS_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, ctrl_o.accept |=> state_q != S_IDLE)
  `HBOS_ASSERT(a_valid_from_load, clk_i, rst_ni, $rose(out_valid_q) |-> $past(ctrl_o.load_out))

endmodule

// File: sv/hbos_dp.sv
// ----------------------------------------------------------------------------
// hbos_dp
// Bitmap datapath: summary word, leaf RAM, bit scans, count and result regs.
// ----------------------------------------------------------------------------
`include "hierarchical_bitmap_ordered_set_assert.svh"

module hbos_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hbos_pkg::ctrl_t                   ctrl_i,
  output hbos_pkg::dp_stat_t                stat_o,
  input  logic                              cfg_we_i,
  input  logic [hbos_pkg::UNIV_W-1:0]       cfg_data_i,
  input  logic [hbos_pkg::CMD_W-1:0]        command_i,
  input  logic signed [hbos_pkg::KEY_W-1:0] key_i,
  output logic [hbos_pkg::STAT_W-1:0]       status_o,
  output logic signed [hbos_pkg::KEY_W-1:0] found_value_o,
  output logic [hbos_pkg::UNIV_W-1:0]       element_count_o
);
  import hbos_pkg::*;

  logic [UNIV_W-1:0]  univ_q;
  word_t              summary_q, sum_d;
  logic [UNIV_W-1:0]  count_q, count_d;

  cmd_e               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [ELEM_W-1:0]  x_q;
  logic [LEAF_AW-1:0] w2_q, w2_d;
  logic               w2_ok_q, w2_ok_d;
  status_e            res_status_q, out_status_q;
  logic [KEY_W-1:0]   res_found_q, out_found_q;
  logic [UNIV_W-1:0]  out_count_q;

  // universe bound
  logic [UNIV_W-1:0] n, n_m1;
  assign n    = (univ_q > UNIV_MAX) ? UNIV_MAX : univ_q;
  assign n_m1 = n - UNIV_W'(1);

  // accept-time decode
  cmd_e               cmd_in;
  logic signed [KEY_W:0] key_x, key_p1, key_s;
  logic [KEY_W-1:0]   key_c;
  logic [UNIV_W-1:0]  key_lo, x_pred;
  logic               key_neg, in_range, bound_none;
  logic               early;
  status_e            early_status;
  logic [KEY_W-1:0]   early_found;
  logic [ELEM_W-1:0]  x_acc;

  always_comb begin
    cmd_in     = cmd_e'(command_i);
    key_x      = {key_i[KEY_W-1], key_i};
    key_p1     = key_x + (KEY_W+1)'(1);
    key_s      = (cmd_in == CMD_UPPER) ? key_p1 : key_x;
    key_c      = key_s[KEY_W] ? '0 : key_s[KEY_W-1:0];
    key_neg    = key_i[KEY_W-1];
    key_lo     = key_i[UNIV_W-1:0];
    in_range   = !key_neg && (key_lo < n);
    bound_none = key_c >= KEY_W'(n);
    x_pred     = (key_lo > n_m1) ? n_m1 : key_lo;

    early        = 1'b0;
    early_status = ST_FALSE;
    early_found  = key_i;
    x_acc        = key_lo[ELEM_W-1:0];
    case (cmd_in)
      CMD_INSERT, CMD_ERASE: begin
        if (!in_range) begin
          early        = 1'b1;
          early_status = ST_RANGE;
        end
      end
      CMD_CONTAINS: early = !in_range;
      CMD_LOWER, CMD_UPPER: begin
        x_acc = key_c[ELEM_W-1:0];
        if (bound_none) begin
          early       = 1'b1;
          early_found = KEY_W'(n);
        end
      end
      CMD_PRED: begin
        x_acc = x_pred[ELEM_W-1:0];
        if (key_neg || (n == '0)) begin
          early       = 1'b1;
          early_found = FOUND_NONE;
        end
      end
      default: early = 1'b1;
    endcase
  end

  // summary scan for the neighboring non-empty leaf
  logic [LEAF_AW-1:0] w1;
  logic               is_pred;
  word_t              up_mask, dn_mask, cand;

  assign w1      = x_q[ELEM_W-1:BIT_AW];
  assign is_pred = (cmd_q == CMD_PRED);

  always_comb begin
    up_mask = ~((word_t'(2) << w1) - word_t'(1));
    dn_mask = (word_t'(1) << w1) - word_t'(1);
    cand    = summary_q & (is_pred ? dn_mask : up_mask);
    w2_d    = is_pred ? msb_index(cand) : lsb_index(cand);
    w2_ok_d = (cand != '0);
  end

  // leaf memory
  word_t              rdata, new_leaf;
  logic               leaf_wr;
  logic [LEAF_AW-1:0] raddr;

  assign raddr = ctrl_i.rd2 ? w2_q : w1;

  hbos_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LEAF_COUNT)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (leaf_wr && ctrl_i.ev1),
    .waddr_i (w1),
    .wdata_i (new_leaf),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // first leaf evaluation; a clear summary bit means the leaf is empty
  word_t             leaf, onehot, m;
  logic [BIT_AW-1:0] b;
  logic              bit_set, m_any, chain;
  logic [ELEM_W-1:0] r1;
  status_e           ev_status;
  logic [KEY_W-1:0]  ev_found;

  always_comb begin
    leaf    = summary_q[w1] ? rdata : '0;
    b       = x_q[BIT_AW-1:0];
    onehot  = word_t'(1) << b;
    bit_set = |(leaf & onehot);
    m       = is_pred ? (leaf & ((word_t'(2) << b) - word_t'(1)))
                      : (leaf & (word_t'('1) << b));
    m_any   = |m;
    r1      = {w1, (is_pred ? msb_index(m) : lsb_index(m))};

    leaf_wr   = 1'b0;
    new_leaf  = leaf;
    sum_d     = summary_q;
    count_d   = count_q;
    ev_status = ST_FALSE;
    ev_found  = key_q;
    chain     = 1'b0;
    case (cmd_q)
      CMD_INSERT: begin
        if (!bit_set) begin
          leaf_wr   = 1'b1;
          new_leaf  = leaf | onehot;
          sum_d[w1] = 1'b1;
          count_d   = count_q + UNIV_W'(1);
          ev_status = ST_OK;
        end
      end
      CMD_ERASE: begin
        if (bit_set) begin
          leaf_wr  = 1'b1;
          new_leaf = leaf & ~onehot;
          if (new_leaf == '0) begin
            sum_d[w1] = 1'b0;
          end
          count_d   = count_q - UNIV_W'(1);
          ev_status = ST_OK;
        end
      end
      CMD_CONTAINS: ev_status = bit_set ? ST_OK : ST_FALSE;
      CMD_LOWER, CMD_UPPER: begin
        if (m_any) begin
          if (UNIV_W'(r1) < n) begin
            ev_status = ST_OK;
            ev_found  = KEY_W'(r1);
          end else begin
            ev_found  = KEY_W'(n);
          end
        end else if (w2_ok_q) begin
          chain = 1'b1;
        end else begin
          ev_found = KEY_W'(n);
        end
      end
      CMD_PRED: begin
        if (m_any) begin
          ev_status = ST_OK;
          ev_found  = KEY_W'(r1);
        end else if (w2_ok_q) begin
          chain = 1'b1;
        end else begin
          ev_found = FOUND_NONE;
        end
      end
      default: ;
    endcase
  end

  // second leaf evaluation
  logic [ELEM_W-1:0] r2;
  status_e           ev2_status;
  logic [KEY_W-1:0]  ev2_found;

  always_comb begin
    r2 = {w2_q, (is_pred ? msb_index(rdata) : lsb_index(rdata))};
    if (is_pred || (UNIV_W'(r2) < n)) begin
      ev2_status = ST_OK;
      ev2_found  = KEY_W'(r2);
    end else begin
      ev2_status = ST_FALSE;
      ev2_found  = KEY_W'(n);
    end
  end

  assign stat_o.early = early;
  assign stat_o.chain = chain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      univ_q    <= UNIV_RESET;
      summary_q <= '0;
      count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        univ_q <= cfg_data_i;
      end
      if (ctrl_i.ev1) begin
        summary_q <= sum_d;
        count_q   <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q        <= cmd_in;
      key_q        <= key_i;
      x_q          <= x_acc;
      res_status_q <= early_status;
      res_found_q  <= early_found;
    end
    if (ctrl_i.rd1) begin
      w2_q    <= w2_d;
      w2_ok_q <= w2_ok_d;
    end
    if (ctrl_i.ev1) begin
      res_status_q <= ev_status;
      res_found_q  <= ev_found;
    end
    if (ctrl_i.ev2) begin
      res_status_q <= ev2_status;
      res_found_q  <= ev2_found;
    end
    if (ctrl_i.load_out) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_count_q  <= count_q;
    end
  end

  assign status_o        = out_status_q;
  assign found_value_o   = out_found_q;
  assign element_count_o = out_count_q;

  logic insert_hit;
  assign insert_hit = ctrl_i.ev1 && (cmd_q == CMD_INSERT) && (ev_status == ST_OK);

  `HBOS_ASSERT(a_count_only_on_eval, clk_i, rst_ni, !ctrl_i.ev1 |=> $stable(count_q))
  `HBOS_ASSERT(a_insert_marks_summary, clk_i, rst_ni, insert_hit |=> summary_q[$past(w1)])
  `HBOS_ASSERT_ALWAYS(a_count_bounded, clk_i, !rst_ni || (count_q <= UNIV_MAX))

endmodule
